// ----- rtl/plsc_pkg.sv -----
package plsc_pkg;

	// Strip geometry.
	localparam int NUM_LEDS = 10;

	// Field and register widths.
	localparam int HOLD_W     = 16;
	localparam int STEP_W     = 8;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Animation modes as reported on active_mode.
	localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 1'd1;

	// Register reset values.
	localparam logic [HOLD_W-1:0] LONG_PRESS_RESET    = 16'd30;
	localparam logic [STEP_W-1:0] STEP_INTERVAL_RESET = 8'd2;
	localparam logic [HOLD_W-1:0] HOLD_MAX            = {HOLD_W{1'b1}};

	// Common control broadcast from the sequencer to every LED cell.
	typedef struct packed {
		logic en;    // a tick beat is taken this cycle
		logic load;  // restart at LED 0 before any move
		logic shr;   // move toward the high end
		logic shl;   // move toward LED 0
		logic dbl;   // light the neighbor above the lit position too
	} cell_ctrl_t;

endpackage

// ----- rtl/press_length_led_bounce_scanner_core.sv -----
// Button-driven bounce scanner for a strip of plsc_pkg::NUM_LEDS LEDs.
//
// The input channel (in_valid / in_ready / button_level) carries one beat per
// tick with the sampled button level. Every accepted beat yields exactly one
// result beat on the output channel (out_valid / out_ready) holding the LED
// pattern and the mode that hold after that tick.
//
// An accepted beat is registered in the main output register, or in the skid
// register while the receiver stalls. One beat per cycle is taken while in_ready
// is high; the tick update is a single pass through the sequencer and LED cells.
// A two-entry output stage (main register plus skid register) parts the two
// sides, so in_ready stays high while one finished result waits. in_ready
// drops only once both entries hold results the receiver has not taken.
//
// Reset clears the button history, the hold counter and the step counter,
// sets the mode to idle with the direction set to right and no cell holding the spot, and empties
// the output stage. The long-press threshold returns to 30 ticks and the
// step interval to 2 ticks. The configuration port writes a register at any
// edge with cfg_we high; it is meant to be used while the block is idle.
module press_length_led_bounce_scanner_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [plsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               button_level,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [plsc_pkg::NUM_LEDS-1:0]      led_pattern,
	output logic [plsc_pkg::MODE_W-1:0]        active_mode
);

	// Configuration registers.
	logic [plsc_pkg::HOLD_W-1:0] long_press_q;
	logic [plsc_pkg::STEP_W-1:0] interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= plsc_pkg::LONG_PRESS_RESET;
			interval_q   <= plsc_pkg::STEP_INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				plsc_pkg::REG_LONG_PRESS: begin
					long_press_q <= cfg_data;
				end
				plsc_pkg::REG_STEP_INTERVAL: begin
					interval_q <= cfg_data[plsc_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// A tick is taken whenever the skid entry is free.
	logic accept;
	logic skid_valid_q;

	assign in_ready = ~skid_valid_q;
	assign accept   = in_valid & in_ready;

	// Sequencer: button edges, mode choice and step timing.
	plsc_pkg::cell_ctrl_t          cell_ctrl;
	logic [plsc_pkg::MODE_W-1:0]   mode_next;
	logic [plsc_pkg::NUM_LEDS-1:0] lit;
	logic [plsc_pkg::NUM_LEDS-1:0] base;
	logic [plsc_pkg::NUM_LEDS-1:0] next;
	logic [plsc_pkg::NUM_LEDS-1:0] led;

	plsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.button     (button_level),
		.lit        (lit),
		.long_press (long_press_q),
		.interval   (interval_q),
		.cell_ctrl  (cell_ctrl),
		.mode_next  (mode_next)
	);

	// Row of LED cells. The lit spot is one-hot across the row; a move right
	// takes the bit from the lower neighbor, a move left from the upper one.
	// Each cell also lights itself when double mode has the spot just below.
	for (genvar i = 0; i < plsc_pkg::NUM_LEDS; i++) begin : g_cell
		logic lower_base;
		logic upper_base;
		logic lower_next;

		if (i == 0) begin : g_low_end
			assign lower_base = 1'b0;
			assign lower_next = 1'b0;
		end else begin : g_low_mid
			assign lower_base = base[i-1];
			assign lower_next = next[i-1];
		end

		if (i == plsc_pkg::NUM_LEDS - 1) begin : g_high_end
			assign upper_base = 1'b0;
		end else begin : g_high_mid
			assign upper_base = base[i+1];
		end

		plsc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.init_bit   (1'(i == 0)),
			.lower_base (lower_base),
			.upper_base (upper_base),
			.lower_next (lower_next),
			.lit_bit    (lit[i]),
			.base_bit   (base[i]),
			.next_bit   (next[i]),
			.led_bit    (led[i])
		);
	end

	// The strip is dark until the first release picks a mode.
	logic [plsc_pkg::NUM_LEDS-1:0] pattern_new;

	assign pattern_new = (mode_next == plsc_pkg::MODE_IDLE) ? '0 : led;

	// Output stage: main register toward the receiver and a skid register
	// that catches one result while the receiver stalls.
	logic                          out_valid_q;
	logic [plsc_pkg::NUM_LEDS-1:0] out_pattern_q;
	logic [plsc_pkg::MODE_W-1:0]   out_mode_q;
	logic [plsc_pkg::NUM_LEDS-1:0] skid_pattern_q;
	logic [plsc_pkg::MODE_W-1:0]   skid_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q | accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_pattern_q <= skid_pattern_q;
				out_mode_q    <= skid_mode_q;
			end else if (accept) begin
				out_pattern_q <= pattern_new;
				out_mode_q    <= mode_next;
			end
		end else if (accept) begin
			skid_pattern_q <= pattern_new;
			skid_mode_q    <= mode_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign led_pattern = out_pattern_q;
	assign active_mode = out_mode_q;

endmodule

// ----- rtl/plsc_cell.sv -----
// One LED position of the scanner: holds whether the lit spot sits here and
// passes it to a neighbor when the spot moves.
module plsc_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  plsc_pkg::cell_ctrl_t ctrl,
	input  logic                 init_bit,
	input  logic                 lower_base,
	input  logic                 upper_base,
	input  logic                 lower_next,
	output logic                 lit_bit,
	output logic                 base_bit,
	output logic                 next_bit,
	output logic                 led_bit
);

	logic lit_q;

	assign lit_bit  = lit_q;
	assign base_bit = ctrl.load ? init_bit : lit_q;
	assign next_bit = ctrl.shr ? lower_base : (ctrl.shl ? upper_base : base_bit);
	assign led_bit  = next_bit | (ctrl.dbl & lower_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q <= 1'b0;
		end else if (ctrl.en) begin
			lit_q <= next_bit;
		end
	end

endmodule

// ----- rtl/plsc_ctrl.sv -----
// Button tracking, mode choice and step timing for the cell row.
module plsc_ctrl (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     button,
	input  logic [plsc_pkg::NUM_LEDS-1:0]            lit,
	input  logic [plsc_pkg::HOLD_W-1:0]              long_press,
	input  logic [plsc_pkg::STEP_W-1:0]              interval,
	output plsc_pkg::cell_ctrl_t                     cell_ctrl,
	output logic [plsc_pkg::MODE_W-1:0]              mode_next
);

	logic                          prev_q;
	logic                          right_q;
	logic [plsc_pkg::HOLD_W-1:0]   hold_q;
	logic [plsc_pkg::STEP_W-1:0]   step_q;
	logic [plsc_pkg::MODE_W-1:0]   mode_q;

	logic                          press;
	logic                          release_edge;
	logic [plsc_pkg::HOLD_W-1:0]   hold_next;
	logic                          right_base;
	logic                          right_next;
	logic [plsc_pkg::STEP_W-1:0]   step_inc;
	logic [plsc_pkg::STEP_W-1:0]   step_next;
	logic                          do_step;
	logic                          at_limit;
	logic                          at_zero;

	always_comb begin
		press        = button & ~prev_q;
		release_edge = ~button & prev_q;

		if (press) begin
			hold_next = plsc_pkg::HOLD_W'(1);
		end else if (button && hold_q != plsc_pkg::HOLD_MAX) begin
			hold_next = hold_q + plsc_pkg::HOLD_W'(1);
		end else begin
			hold_next = hold_q;
		end

		if (release_edge) begin
			mode_next = (hold_q >= long_press) ? plsc_pkg::MODE_DOUBLE : plsc_pkg::MODE_SINGLE;
		end else begin
			mode_next = mode_q;
		end

		right_base = release_edge ? 1'b1 : right_q;
		step_inc   = (release_edge ? '0 : step_q) + plsc_pkg::STEP_W'(1);
		do_step    = (mode_next != plsc_pkg::MODE_IDLE) && (step_inc >= interval);

		// On a release the spot restarts at LED 0, which is never the right end.
		if (release_edge) begin
			at_limit = 1'b0;
			at_zero  = 1'b1;
		end else begin
			at_limit = (mode_next == plsc_pkg::MODE_DOUBLE) ? lit[plsc_pkg::NUM_LEDS-2]
			                                                : lit[plsc_pkg::NUM_LEDS-1];
			at_zero  = lit[0];
		end

		cell_ctrl.en   = en;
		cell_ctrl.load = release_edge;
		cell_ctrl.shr  = do_step & right_base & ~at_limit;
		cell_ctrl.shl  = do_step & ~right_base & ~at_zero;
		cell_ctrl.dbl  = (mode_next == plsc_pkg::MODE_DOUBLE);

		// Turning around at an end takes a whole step without a move.
		if (do_step && right_base && at_limit) begin
			right_next = 1'b0;
		end else if (do_step && !right_base && at_zero) begin
			right_next = 1'b1;
		end else begin
			right_next = right_base;
		end

		if (mode_next == plsc_pkg::MODE_IDLE) begin
			step_next = step_q;
		end else if (do_step) begin
			step_next = '0;
		end else begin
			step_next = step_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			right_q <= 1'b1;
			hold_q  <= '0;
			step_q  <= '0;
			mode_q  <= plsc_pkg::MODE_IDLE;
		end else if (en) begin
			prev_q  <= button;
			right_q <= right_next;
			hold_q  <= hold_next;
			step_q  <= step_next;
			mode_q  <= mode_next;
		end
	end

endmodule

// ----- rtl/plsc_checker.sv -----
module plsc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_we,
	input logic [plsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [plsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               button_level,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [plsc_pkg::NUM_LEDS-1:0]      led_pattern,
	input logic [plsc_pkg::MODE_W-1:0]        active_mode
);

	// A stalled result beat holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(led_pattern) && $stable(active_mode))
		else $error("result beat changed while stalled");

	// Idle results show a dark strip.
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && active_mode == plsc_pkg::MODE_IDLE |-> led_pattern == '0)
		else $error("LEDs lit while idle");

	// Single mode lights exactly one LED.
	a_single_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && active_mode == plsc_pkg::MODE_SINGLE |-> $onehot(led_pattern))
		else $error("single mode pattern is not one LED");

	// Double mode lights exactly two LEDs.
	a_double_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && active_mode == plsc_pkg::MODE_DOUBLE |-> $countones(led_pattern) == 2)
		else $error("double mode pattern is not two LEDs");

	// Once a mode is running the block never falls back to idle.
	a_mode_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && active_mode != plsc_pkg::MODE_IDLE
		##1 out_valid |-> active_mode != plsc_pkg::MODE_IDLE)
		else $error("mode returned to idle");

endmodule

bind press_length_led_bounce_scanner_core plsc_checker u_plsc_checker (.*);
